// ===== hdl/ptt_pkg.sv =====
// Package for the periodic timer table: opcodes, result kinds, field widths
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package ptt_pkg;

   localparam int SLOTS_DEF = 16;

   localparam int OP_W     = 2;
   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 31;
   localparam int SID_W    = 4;
   localparam int KIND_W   = 3;
   localparam int SLOT_W   = 4;
   localparam int COUNT_W  = 5;
   localparam int WORD_W   = TIME_W + PERIOD_W + 1;

   localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
   localparam logic [OP_W-1:0] OP_REGISTER  = 2'd1;
   localparam logic [OP_W-1:0] OP_UNREG     = 2'd2;
   localparam logic [OP_W-1:0] OP_UNREG_ALL = 2'd3;

   localparam logic [KIND_W-1:0] KIND_FIRED   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 3'd1;
   localparam logic [KIND_W-1:0] KIND_GRANTED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FULL    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FREED   = 3'd4;

   typedef struct packed {
      logic load;
      logic inc;
      logic rd_issue;
      logic eval;
      logic summary;
      logic grant;
      logic full;
      logic unreg;
   } cmd_type;

   typedef struct packed {
      logic free;
      logic cnt_last;
      logic eval_last;
   } status_type;

endpackage
`default_nettype wire

// ===== hdl/ptt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ptt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/ptt_ctrl.sv =====
// Controller FSM for the periodic timer table: sequences tick scans,
// free-slot search and unregister beats. Depends on ptt_pkg.
`default_nettype none
module ptt_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ptt_pkg::OP_W-1:0]      req_op,
   input  wire ptt_pkg::status_type           status,
   output ptt_pkg::cmd_type                   cmd,
   output logic                               busy
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_TFIRST = 3'd1;
   localparam logic [2:0] S_TRUN   = 3'd2;
   localparam logic [2:0] S_TSUM   = 3'd3;
   localparam logic [2:0] S_RSCAN  = 3'd4;
   localparam logic [2:0] S_UNREG  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (req_op)
                  ptt_pkg::OP_TICK:     state_in = S_TFIRST;
                  ptt_pkg::OP_REGISTER: state_in = S_RSCAN;
                  default:              state_in = S_UNREG;
               endcase
            end
         end
         S_TFIRST: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_TRUN;
         end
         S_TRUN: begin
            cmd.eval     = 1'b1;
            cmd.rd_issue = !status.eval_last;
            if (status.eval_last) begin
               state_in = S_TSUM;
            end
         end
         S_TSUM: begin
            cmd.summary = 1'b1;
            state_in    = S_IDLE;
         end
         S_RSCAN: begin
            if (status.free) begin
               cmd.grant = 1'b1;
               state_in  = S_IDLE;
            end else if (status.cnt_last) begin
               cmd.full = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.inc = 1'b1;
            end
         end
         S_UNREG: begin
            cmd.unreg = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

// ===== hdl/ptt_datapath.sv =====
// Datapath for the periodic timer table: request registers, slot valid bits,
// slot RAM, deadline compare/advance and result registers.
// Depends on ptt_pkg and ptt_ram.
`default_nettype none
module ptt_datapath #(
   parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ptt_pkg::cmd_type                  cmd,
   output ptt_pkg::status_type                    status,
   input  wire logic [ptt_pkg::OP_W-1:0]          req_op,
   input  wire logic [ptt_pkg::TIME_W-1:0]        req_now_us,
   input  wire logic [ptt_pkg::PERIOD_W-1:0]      req_period_us,
   input  wire logic                              req_one_shot,
   input  wire logic [ptt_pkg::SID_W-1:0]         req_slot_id,
   output logic                                   rsp_valid,
   output logic      [ptt_pkg::KIND_W-1:0]        rsp_kind,
   output logic      [ptt_pkg::SLOT_W-1:0]        rsp_slot,
   output logic      [ptt_pkg::COUNT_W-1:0]       rsp_fired_count,
   output logic                                   rsp_last
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

   logic [ptt_pkg::OP_W-1:0]     op_ff, op_in;
   logic [ptt_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [ptt_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic                         once_ff, once_in;
   logic [ptt_pkg::SID_W-1:0]    sid_ff, sid_in;
   logic [IDX_W-1:0]             cnt_ff, cnt_in;
   logic [IDX_W-1:0]             eval_ff, eval_in;
   logic [CNT_W-1:0]             fired_ff, fired_in;
   logic [SLOTS-1:0]             valid_ff, valid_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ptt_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [ptt_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [ptt_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         ram_wr_en;
   logic [IDX_W-1:0]             ram_wr_addr;
   logic [ptt_pkg::WORD_W-1:0]   ram_wr_data;
   logic [ptt_pkg::WORD_W-1:0]   ram_rd_data;

   logic [ptt_pkg::TIME_W-1:0]   rd_deadline;
   logic [ptt_pkg::PERIOD_W-1:0] rd_period;
   logic                         rd_once;
   logic [ptt_pkg::TIME_W-1:0]   diff;
   logic                         due;
   logic [7:0]                   cnt_wide, eval_wide, sid_wide, fired_wide;
   logic                         sid_in_range;

   ptt_ram #(
      .WIDTH (ptt_pkg::WORD_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (cnt_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_deadline = ram_rd_data[ptt_pkg::TIME_W-1:0];
   assign rd_period   = ram_rd_data[ptt_pkg::TIME_W +: ptt_pkg::PERIOD_W];
   assign rd_once     = ram_rd_data[ptt_pkg::WORD_W-1];
   assign diff        = now_ff - rd_deadline;
   assign due         = valid_ff[eval_ff] && !diff[ptt_pkg::TIME_W-1];

   assign cnt_wide     = 8'(cnt_ff);
   assign eval_wide    = 8'(eval_ff);
   assign sid_wide     = 8'(sid_ff);
   assign fired_wide   = 8'(fired_ff);
   assign sid_in_range = (sid_wide < 8'(SLOTS));

   assign status.free      = !valid_ff[cnt_ff];
   assign status.cnt_last  = (cnt_ff == IDX_LAST);
   assign status.eval_last = (eval_ff == IDX_LAST);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = eval_ff;
      ram_wr_data = {rd_once, rd_period, rd_deadline + 32'(rd_period)};
      if (cmd.grant) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = cnt_ff;
         ram_wr_data = {once_ff, period_ff, now_ff + 32'(period_ff)};
      end else if (cmd.eval && due && !rd_once) begin
         ram_wr_en = 1'b1;
      end
   end

   always_comb begin
      op_in        = op_ff;
      now_in       = now_ff;
      period_in    = period_ff;
      once_in      = once_ff;
      sid_in       = sid_ff;
      cnt_in       = cnt_ff;
      eval_in      = eval_ff;
      fired_in     = fired_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.load) begin
         op_in     = req_op;
         now_in    = req_now_us;
         period_in = req_period_us;
         once_in   = req_one_shot;
         sid_in    = req_slot_id;
         cnt_in    = '0;
         fired_in  = '0;
      end
      if (cmd.inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.rd_issue) begin
         eval_in = cnt_ff;
         cnt_in  = cnt_ff + 1'b1;
      end
      if (cmd.eval && due) begin
         fired_in     = fired_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_kind_in  = ptt_pkg::KIND_FIRED;
         rsp_slot_in  = eval_wide[ptt_pkg::SLOT_W-1:0];
         rsp_count_in = '0;
         rsp_last_in  = 1'b0;
         if (rd_once) begin
            valid_in[eval_ff] = 1'b0;
         end
      end
      if (cmd.summary) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = ptt_pkg::KIND_SUMMARY;
         rsp_slot_in  = '0;
         rsp_count_in = fired_wide[ptt_pkg::COUNT_W-1:0];
         rsp_last_in  = 1'b1;
      end
      if (cmd.grant) begin
         valid_in[cnt_ff] = 1'b1;
         rsp_valid_in     = 1'b1;
         rsp_kind_in      = ptt_pkg::KIND_GRANTED;
         rsp_slot_in      = cnt_wide[ptt_pkg::SLOT_W-1:0];
         rsp_count_in     = '0;
         rsp_last_in      = 1'b1;
      end
      if (cmd.full) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = ptt_pkg::KIND_FULL;
         rsp_slot_in  = '0;
         rsp_count_in = '0;
         rsp_last_in  = 1'b1;
      end
      if (cmd.unreg) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = ptt_pkg::KIND_FREED;
         rsp_count_in = '0;
         rsp_last_in  = 1'b1;
         if (op_ff == ptt_pkg::OP_UNREG_ALL) begin
            valid_in    = '0;
            rsp_slot_in = '0;
         end else begin
            rsp_slot_in = sid_ff;
            if (sid_in_range) begin
               valid_in[sid_wide[IDX_W-1:0]] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      now_ff       <= now_in;
      period_ff    <= period_in;
      once_ff      <= once_in;
      sid_ff       <= sid_in;
      cnt_ff       <= cnt_in;
      eval_ff      <= eval_in;
      fired_ff     <= fired_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_fired_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire

// ===== hdl/periodic_timer_table_top.sv =====
// Top level of the periodic timer table: controller FSM plus datapath.
// Depends on ptt_pkg, ptt_ctrl, ptt_datapath (and ptt_ram below it).
//
// Items are taken when start is high and busy is low; busy is high until the
// last result beat of the item has been issued, after which the next start
// is taken. Results appear as single-cycle beats on rsp_* marked by rsp_valid,
// and the receiver cannot stall them. A tick walks the slot RAM through its
// one read port, one slot per cycle: a first read in S_TFIRST, the walk in
// S_TRUN, then S_TSUM; fired beats come out during the walk and the summary
// beat last. A register request walks the valid bits for the lowest free
// slot. Unregister and unregister-all are handled in state S_UNREG.
// No clearing pass is needed after reset.
`default_nettype none
module periodic_timer_table_top #(
   parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [ptt_pkg::OP_W-1:0]          req_op,
   input  wire logic [ptt_pkg::TIME_W-1:0]        req_now_us,
   input  wire logic [ptt_pkg::PERIOD_W-1:0]      req_period_us,
   input  wire logic                              req_one_shot,
   input  wire logic [ptt_pkg::SID_W-1:0]         req_slot_id,
   output logic                                   rsp_valid,
   output logic      [ptt_pkg::KIND_W-1:0]        rsp_kind,
   output logic      [ptt_pkg::SLOT_W-1:0]        rsp_slot,
   output logic      [ptt_pkg::COUNT_W-1:0]       rsp_fired_count,
   output logic                                   rsp_last
);

   ptt_pkg::cmd_type    cmd;
   ptt_pkg::status_type status;

   ptt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ptt_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_now_us      (req_now_us),
      .req_period_us   (req_period_us),
      .req_one_shot    (req_one_shot),
      .req_slot_id     (req_slot_id),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_slot        (rsp_slot),
      .rsp_fired_count (rsp_fired_count),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire
